### design/fpm_pkg.sv
// Package of shared types and constants for the frame PSNR meter.
package fpm_pkg;

	localparam int PIXEL_COUNT_BITS = 22;
	localparam int FRAC_BITS = 8;
	localparam int CNT_W = PIXEL_COUNT_BITS + 1;
	localparam int ACC_W = 40;
	localparam int LOG_FRAC = 24;
	localparam int LOG_W = LOG_FRAC + 6;
	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
	localparam logic [17:0] PEAK_X3 = 18'd195075;
	localparam logic [31:0] TEN_LOG10_2_Q30 = 32'd3232284966;
	localparam logic [14:0] PSNR_MAX = 15'd32767;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// One finished frame handed from the accumulator to the log unit.
	typedef struct packed {
		logic [ACC_W-1:0] sse;
		logic [CNT_W-1:0] pixels;
		logic             ovf;
	} frame_rec_t;

	typedef struct packed {
		logic [14:0]      psnr;
		logic             identical;
		logic [ACC_W-1:0] sse;
		logic             ovf;
	} result_t;

endpackage

### design/fpm_front.sv
// Front end: accepts pixels, accumulates squared error and counts pixels.
module fpm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [47:0]         in_data,
	input  logic                in_last,
	output logic                rec_valid,
	input  logic                rec_ready,
	output fpm_pkg::frame_rec_t rec
);
	import fpm_pkg::*;

	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic [8:0] d0, d1, d2;
	logic [17:0] e;
	logic [ACC_W:0] sum;
	logic [ACC_W-1:0] acc_n;
	logic [CNT_W-1:0] cnt_n;
	logic             ovf_n;
	logic             take;

	function automatic logic [8:0] adiff(input logic [7:0] a, input logic [7:0] b);
		return (a >= b) ? {1'b0, a - b} : {1'b0, b - a};
	endfunction

	assign d0 = adiff(in_data[7:0], in_data[31:24]);
	assign d1 = adiff(in_data[15:8], in_data[39:32]);
	assign d2 = adiff(in_data[23:16], in_data[47:40]);
	assign e = 18'(d0) * 18'(d0) + 18'(d1) * 18'(d1) + 18'(d2) * 18'(d2);
	assign sum = {1'b0, acc_q} + {{(ACC_W-17){1'b0}}, e};
	assign acc_n = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
	assign ovf_n = ovf_q | cnt_q[CNT_W-1];
	assign cnt_n = cnt_q[CNT_W-1] ? cnt_q : cnt_q + 1'b1;

	// A frame-end pixel waits until the queue has room.
	assign in_ready = !in_last || rec_ready;
	assign take = in_valid && in_ready;
	assign rec_valid = take && in_last;
	assign rec.sse = acc_n;
	assign rec.pixels = cnt_n;
	assign rec.ovf = ovf_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (take) begin
			if (in_last) begin
				acc_q <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				acc_q <= acc_n;
				cnt_q <= cnt_n;
				ovf_q <= ovf_n;
			end
		end
	end
endmodule

### design/fpm_queue.sv
// Short queue of finished frames between the front and back ends.
module fpm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_ready,
	input  fpm_pkg::frame_rec_t wr_data,
	output logic                rd_valid,
	input  logic                rd_ready,
	output fpm_pkg::frame_rec_t rd_data
);
	import fpm_pkg::*;

	frame_rec_t     mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   n_q;
	logic wr, rd;

	assign wr_ready = (n_q != QPTR_W'(0) + (QPTR_W+1)'(QDEPTH));
	assign rd_valid = (n_q != '0);
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			n_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			if (wr && !rd) n_q <= n_q + 1'b1;
			else if (rd && !wr) n_q <= n_q - 1'b1;
		end
	end
endmodule

### design/fpm_back.sv
// Back end: iterative log2 of signal and error, PSNR scaling, output register.
module fpm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rec_valid,
	output logic                rec_ready,
	input  fpm_pkg::frame_rec_t rec,
	output logic                res_valid,
	input  logic                res_ready,
	output fpm_pkg::result_t    res
);
	import fpm_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_NORM = 3'd1;
	localparam logic [2:0] ST_SQR  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_SCL  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;
	localparam logic [2:0] ST_RND  = 3'd6;

	logic [2:0]  st_q;
	logic [4:0]  k_q;
	logic        sel_q;
	frame_rec_t  r_q;
	logic [63:0] x_q;
	logic [32:0] m_q;
	logic [5:0]  p_q;
	logic [LOG_W-1:0] ln_q, ld_q;
	logic [LOG_W-1:0] d_q;
	logic [62:0] prod_q;
	logic [63:0] msq;
	logic [32:0] mn;
	logic [5:0]  pe;
	logic [31:0] mnorm;

	// Leading-one position; value is narrow enough for a priority scan.
	always_comb begin
		pe = '0;
		for (int i = 1; i < 64; i++) if (x_q[i]) pe = 6'(i);
	end
	always_comb begin
		if (pe >= 6'd31) mnorm = 32'(x_q >> (pe - 6'd31));
		else mnorm = 32'(x_q << (6'd31 - pe));
	end
	assign msq = 64'(m_q[31:0]) * 64'(m_q[31:0]);
	assign mn = 33'(msq >> 31);

	assign rec_ready = (st_q == ST_IDLE);
	assign res_valid = (st_q == ST_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			k_q <= '0;
			sel_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: if (rec_valid) begin
					r_q <= rec;
					x_q <= 64'(rec.pixels) * 64'(PEAK_X3);
					sel_q <= 1'b0;
					st_q <= (rec.sse == '0) ? ST_OUT : ST_NORM;
					res.psnr <= '0;
					res.identical <= (rec.sse == '0);
					res.sse <= rec.sse;
					res.ovf <= rec.ovf;
				end
				ST_NORM: begin
					p_q <= pe;
					m_q <= {1'b0, mnorm};
					k_q <= '0;
					ln_q <= '0;
					st_q <= ST_SQR;
				end
				ST_SQR: begin
					if (mn[32]) m_q <= {1'b0, mn[32:1]};
					else m_q <= mn;
					ln_q <= {ln_q[LOG_W-2:0], mn[32]};
					k_q <= k_q + 1'b1;
					if (k_q == 5'(LOG_FRAC - 1)) begin
						if (!sel_q) begin
							ld_q <= {p_q, ln_q[LOG_FRAC-2:0], mn[32]};
							x_q <= 64'(r_q.sse);
							sel_q <= 1'b1;
							st_q <= ST_NORM;
						end else begin
							st_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					// ld_q holds the signal log and ln_q holds the error log here.
					if (ld_q > {p_q, ln_q[LOG_FRAC-1:0]}) begin
						d_q <= ld_q - {p_q, ln_q[LOG_FRAC-1:0]};
						st_q <= ST_SCL;
					end else begin
						st_q <= ST_OUT;
					end
				end
				ST_SCL: begin
					prod_q <= 63'(d_q) * 63'(TEN_LOG10_2_Q30);
					st_q <= ST_RND;
				end
				ST_RND: begin
					logic [63:0] t;
					t = (64'(prod_q) + (64'd1 << (53 - FRAC_BITS))) >> (54 - FRAC_BITS);
					res.psnr <= (t > 64'(PSNR_MAX)) ? PSNR_MAX : t[14:0];
					st_q <= ST_OUT;
				end
				ST_OUT: if (res_ready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### design/frame_psnr_meter_unit.sv
// Top level of the frame PSNR meter.
// Pixels enter on the s_axis channel, one word per pixel: tdata carries the
// reference and current channels, tlast marks the last pixel of a frame.
// A pixel is taken every cycle, except a frame-end word while the queue is full;
// the accumulator adds its squared error at once. On a frame-end word a record
// goes into a four-entry queue; a frame-end word waits only while that queue is full.
// The back end computes two 24-step fixed-point logarithms, one squaring step
// per cycle; a frame with a zero error sum skips them and is flagged identical.
// Results leave on m_axis and are held until taken; while the receiver stalls
// the queue fills and then pixel intake pauses at the next frame end.
// Reset clears the accumulator, the pixel count, the queue and the back end.
module frame_psnr_meter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// reference_ch0, reference_ch1, reference_ch2, current_ch0, current_ch1, current_ch2
	input  logic [47:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// psnr_q8[14:0], error_sum[54:15], zero fill
	output logic [55:0] m_axis_tdata,
	// identical, count_overflow
	output logic [1:0]  m_axis_tuser
);
	import fpm_pkg::*;

	frame_rec_t f_rec, q_rec;
	logic f_valid, f_ready, q_valid, q_ready;
	result_t res;

	fpm_front u_front (.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata), .in_last(s_axis_tlast), .rec_valid(f_valid),
		.rec_ready(f_ready), .rec(f_rec));
	fpm_queue u_queue (.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_rec),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_rec));
	fpm_back u_back (.clk, .arst_n, .rec_valid(q_valid), .rec_ready(q_ready), .rec(q_rec),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res));

	assign m_axis_tdata = {1'b0, res.sse, res.psnr};
	assign m_axis_tuser = {res.ovf, res.identical};
endmodule
